### rtl/sepd_pkg.sv
// shared types, constants and register codes for the scan-line edge point detector
package sepd_pkg;

    localparam int PIX_W      = 8;
    localparam int IN_LANES   = 5;
    localparam int SUM_W      = 11;
    localparam int POS_W      = 12;
    localparam int COORD_W    = 24;
    localparam int PTS_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int THR_W      = 8;
    localparam int LEN_W      = 4;
    localparam int LANE_W     = 3;
    localparam int DEP_W      = 8;
    localparam int TW_W       = 15;
    localparam int IDX_W      = 6;
    localparam int FIFO_DEPTH = 16;
    localparam int CFG_SETTLE = 2;

    localparam int MAX_LANES_DEF = 5;
    localparam int MAX_HALF_DEF  = 8;
    localparam int MAX_SCAN_DEF  = 4096;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_EDGE_THRESHOLD = 3'd0;
    localparam t_cfg_idx REG_HALF_LENGTH    = 3'd1;
    localparam t_cfg_idx REG_LANES_USED     = 3'd2;
    localparam t_cfg_idx REG_DEPTH_LIMIT    = 3'd3;
    localparam t_cfg_idx REG_PICK_FIRST     = 3'd4;
    localparam t_cfg_idx REG_POLARITY       = 3'd5;
    localparam t_cfg_idx REG_MULTI_POINT    = 3'd6;

    localparam logic [THR_W-1:0]  RST_EDGE_THRESHOLD = 8'd20;
    localparam logic [LEN_W-1:0]  RST_HALF_LENGTH    = 4'd2;
    localparam logic [LANE_W-1:0] RST_LANES_USED     = 3'd3;
    localparam logic [DEP_W-1:0]  RST_DEPTH_LIMIT    = 8'd10;
    localparam logic              RST_PICK_FIRST     = 1'b1;
    localparam logic              RST_POLARITY       = 1'b0;
    localparam logic              RST_MULTI_POINT    = 1'b0;

    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             found;
        logic [POS_W-1:0] edge_x;
        logic [POS_W-1:0] edge_y;
        logic [PTS_W-1:0] points_found;
        logic             last;
    } t_result;

    typedef struct packed {
        logic valid;
        logic eos;
        logic border;
        logic gt;
        logic ge;
        logic opp;
    } t_cand;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_pipe_stat;

endpackage

### rtl/sepd_cell.sv
// one window cell: holds a lane sum, passes it on, and weighs it into the step filter
module sepd_cell #(
    parameter int IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic [sepd_pkg::SUM_W-1:0]     i_sum,
    input  logic [sepd_pkg::LEN_W-1:0]     i_len,
    output logic [sepd_pkg::SUM_W-1:0]     o_sum,
    output logic signed [sepd_pkg::SUM_W:0] o_term
);
    import sepd_pkg::*;

    localparam logic [IDX_W-1:0] CELL_POS = IDX_W'(IDX);

    logic [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0] len_x;
    logic [IDX_W-1:0] len2_x;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum;
        end
    end

    assign len_x  = IDX_W'(i_len);
    assign len2_x = len_x << 1;
    assign o_sum  = r_sum;

    // newer half adds, older half subtracts, the center cell sits out
    always_comb begin
        if (CELL_POS < len_x) begin
            o_term = $signed({1'b0, r_sum});
        end else if (CELL_POS > len_x && CELL_POS <= len2_x) begin
            o_term = -$signed({1'b0, r_sum});
        end else begin
            o_term = '0;
        end
    end

endmodule

### rtl/sepd_sum_tree.sv
// two-stage registered adder tree over the cell terms and the threshold compares
module sepd_sum_tree #(
    parameter int MAX_HALF = sepd_pkg::MAX_HALF_DEF,
    parameter int CMP_W    = 18
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [sepd_pkg::SUM_W:0]  i_term [2*MAX_HALF+1],
    input  logic                             i_valid,
    input  logic                             i_eos,
    input  logic                             i_border,
    input  logic [sepd_pkg::COORD_W-1:0]     i_here,
    input  logic                             i_polarity,
    input  logic [sepd_pkg::TW_W-1:0]        i_tw,
    output sepd_pkg::t_cand                  o_cand,
    output logic signed [CMP_W-1:0]          o_c,
    output logic [sepd_pkg::COORD_W-1:0]     o_here,
    output sepd_pkg::t_pipe_stat             o_stat
);
    import sepd_pkg::*;

    localparam int WIN = 2 * MAX_HALF + 1;
    localparam int GRP = 4;
    localparam int NG  = (WIN + GRP - 1) / GRP;
    localparam int DW  = SUM_W + $clog2(MAX_HALF + 1) + 1;

    logic signed [DW-1:0]    n_grp [NG];
    logic signed [DW-1:0]    r_grp [NG];
    logic                    r_s1_valid;
    logic                    r_s1_eos;
    logic                    r_s1_border;
    logic [COORD_W-1:0]      r_s1_here;

    logic signed [DW-1:0]    d_sum;
    logic signed [CMP_W-1:0] c_val;
    logic signed [CMP_W-1:0] tw_s;
    t_cand                   n_cand;
    t_cand                   r_cand;
    logic signed [CMP_W-1:0] r_c;
    logic [COORD_W-1:0]      r_here;

    // stage 1: partial sums of groups of neighboring cells
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
        end
        for (int k = 0; k < WIN; k++) begin
            n_grp[k / GRP] = n_grp[k / GRP] + DW'(i_term[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NG; g++) begin
            r_grp[g] <= n_grp[g];
        end
        r_s1_eos    <= i_eos;
        r_s1_border <= i_border;
        r_s1_here   <= i_here;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    // stage 2: full difference, polarity and compares
    always_comb begin
        d_sum = '0;
        for (int g = 0; g < NG; g++) begin
            d_sum = d_sum + r_grp[g];
        end
        c_val = i_polarity ? -CMP_W'(d_sum) : CMP_W'(d_sum);
        tw_s  = CMP_W'($signed({1'b0, i_tw}));
        n_cand.valid  = r_s1_valid;
        n_cand.eos    = r_s1_eos;
        n_cand.border = r_s1_border;
        n_cand.gt     = c_val > tw_s;
        n_cand.ge     = c_val >= tw_s;
        n_cand.opp    = -c_val > tw_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= c_val;
        r_here <= r_s1_here;
    end

    assign o_cand          = r_cand;
    assign o_c             = r_c;
    assign o_here          = r_here;
    assign o_stat.s1_valid = r_s1_valid;
    assign o_stat.s2_valid = r_cand.valid;

endmodule

### rtl/sepd_decide.sv
// mode logic: peak tracking, first edge with depth check, multi point, scan summary
module sepd_decide #(
    parameter int CMP_W    = 18,
    parameter int MAX_SCAN = sepd_pkg::MAX_SCAN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sepd_pkg::t_cand               i_cand,
    input  logic signed [CMP_W-1:0]       i_c,
    input  logic [sepd_pkg::COORD_W-1:0]  i_here,
    input  logic                          i_pick_first,
    input  logic                          i_multi,
    input  logic [sepd_pkg::DEP_W-1:0]    i_depth,
    output sepd_pkg::t_result             o_res0,
    output sepd_pkg::t_result             o_res1,
    output logic [1:0]                    o_push_n
);
    import sepd_pkg::*;

    localparam int PW = $clog2(MAX_SCAN + 1);

    logic                    r_pend,   n_pend;
    logic [COORD_W-1:0]      r_pcoord, n_pcoord;
    logic [PW-1:0]           r_pidx,   n_pidx;
    logic signed [CMP_W-1:0] r_best,   n_best;
    logic [COORD_W-1:0]      r_bcoord, n_bcoord;
    logic                    r_found,  n_found;
    logic [PW-1:0]           r_rc,     n_rc;
    t_result                 summary;

    always_comb begin
        n_pend   = r_pend;
        n_pcoord = r_pcoord;
        n_pidx   = r_pidx;
        n_best   = r_best;
        n_bcoord = r_bcoord;
        n_found  = r_found;
        n_rc     = r_rc;
        o_res0   = '0;
        o_res1   = '0;
        o_push_n = 2'd0;
        summary  = '0;

        if (i_cand.valid && i_cand.border) begin
            if (i_multi) begin
                if (i_cand.gt) begin
                    if (32'(r_rc) < MAX_SCAN) begin
                        n_rc = r_rc + PW'(1);
                    end
                    o_res0.kind         = KIND_POINT;
                    o_res0.found        = 1'b1;
                    o_res0.edge_x       = i_here[POS_W-1:0];
                    o_res0.edge_y       = i_here[COORD_W-1:POS_W];
                    o_res0.points_found = PTS_W'(n_rc);
                    o_res0.last         = 1'b0;
                    o_push_n            = 2'd1;
                end
            end else if (!i_pick_first) begin
                if (i_cand.ge && i_c > r_best) begin
                    n_best   = i_c;
                    n_bcoord = i_here;
                    n_found  = 1'b1;
                end
            end else if (!r_found) begin
                if (r_pend) begin
                    if (32'(r_pidx) < MAX_SCAN) begin
                        n_pidx = r_pidx + PW'(1);
                    end
                    if (i_cand.opp) begin
                        n_pend = 1'b0;
                    end else if (32'(n_pidx) >= 32'(i_depth)) begin
                        n_pend   = 1'b0;
                        n_found  = 1'b1;
                        n_bcoord = r_pcoord;
                    end
                end
                if (!n_pend && !n_found && i_cand.gt) begin
                    if (i_depth == '0) begin
                        n_found  = 1'b1;
                        n_bcoord = i_here;
                    end else begin
                        n_pend   = 1'b1;
                        n_pcoord = i_here;
                        n_pidx   = '0;
                    end
                end
            end
        end

        if (i_cand.valid && i_cand.eos) begin
            summary.kind = KIND_SUMMARY;
            summary.last = 1'b1;
            if (i_multi) begin
                summary.found        = (n_rc != '0);
                summary.points_found = PTS_W'(n_rc);
            end else begin
                // a candidate still waiting on its depth check is taken at scan end
                if (i_pick_first && n_pend && !n_found) begin
                    n_found  = 1'b1;
                    n_bcoord = n_pcoord;
                end
                summary.found = n_found;
                if (n_found) begin
                    summary.edge_x = n_bcoord[POS_W-1:0];
                    summary.edge_y = n_bcoord[COORD_W-1:POS_W];
                end
            end
            if (o_push_n == 2'd0) begin
                o_res0   = summary;
                o_push_n = 2'd1;
            end else begin
                o_res1   = summary;
                o_push_n = 2'd2;
            end
            n_pend   = 1'b0;
            n_pcoord = '0;
            n_pidx   = '0;
            n_best   = '0;
            n_bcoord = '0;
            n_found  = 1'b0;
            n_rc     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_pidx  <= '0;
            r_best  <= '0;
            r_found <= 1'b0;
            r_rc    <= '0;
        end else begin
            r_pend  <= n_pend;
            r_pidx  <= n_pidx;
            r_best  <= n_best;
            r_found <= n_found;
            r_rc    <= n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcoord <= n_pcoord;
        r_bcoord <= n_bcoord;
    end

endmodule

### rtl/sepd_out_fifo.sv
// result queue taking up to two results a cycle and handing out one while i_stall is low
module sepd_out_fifo (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [1:0]                                 i_push_n,
    input  sepd_pkg::t_result                          i_res0,
    input  sepd_pkg::t_result                          i_res1,
    input  logic                                       i_stall,
    output sepd_pkg::t_result                          o_res,
    output logic                                       o_valid,
    output logic [$clog2(sepd_pkg::FIFO_DEPTH+1)-1:0]  o_count
);
    import sepd_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result        r_mem [FIFO_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + AW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_push_n);
            r_rp  <= r_rp + AW'(pop);
            r_cnt <= r_cnt + CW'(i_push_n) - CW'(pop);
        end
    end

endmodule

### rtl/scanline_edge_point_detector_top.sv
// scan-line edge point detector: lane summing, cell chain filter, mode logic, result queue
//
// Input channel (i_valid / o_stall): one scan position per transfer, five lane pixels,
// the centre coordinate and an end-of-scan flag. A position is taken every cycle while
// o_stall is low, so a scan streams at one position per clock.
// Output channel (o_valid / i_stall): point results (kind 0) and one summary (kind 1,
// last 1) per scan. A position's point, if any, and the summary of the end-of-scan
// transfer are registered in the cell chain and the two adder-tree stages, then pass
// the combinational mode logic into the result queue.
// Edge positions refer to inputs half_length transfers earlier.
// The result queue holds 16 entries; o_stall rises when the results still to come from
// positions in the pipeline might not fit, so a stalled receiver backs the input up
// and nothing is dropped.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; a write holds o_stall high
// from its own cycle on while the threshold product settles. Write only between scans
// or while no position is in flight.
// Reset: synchronous, active low; registers return to their defaults, the queue and
// scan state empty. There is no clearing pass.
module scanline_edge_point_detector_top #(
    parameter int MAX_LANES = sepd_pkg::MAX_LANES_DEF,
    parameter int MAX_HALF  = sepd_pkg::MAX_HALF_DEF,
    parameter int MAX_SCAN  = sepd_pkg::MAX_SCAN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pix_a,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pix_b,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pix_c,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pix_d,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pix_e,
    input  logic [sepd_pkg::POS_W-1:0]        i_pos_x,
    input  logic [sepd_pkg::POS_W-1:0]        i_pos_y,
    input  logic                              i_end_of_scan,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_kind,
    output logic                              o_found,
    output logic [sepd_pkg::POS_W-1:0]        o_edge_x,
    output logic [sepd_pkg::POS_W-1:0]        o_edge_y,
    output logic [sepd_pkg::PTS_W-1:0]        o_points_found,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sepd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sepd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sepd_pkg::*;

    localparam int LIM    = (MAX_LANES < IN_LANES) ? MAX_LANES : IN_LANES;
    localparam int WIN    = 2 * MAX_HALF + 1;
    localparam int DLY    = MAX_HALF + 1;
    localparam int CI_W   = $clog2(DLY);
    localparam int PW     = $clog2(MAX_SCAN + 1);
    localparam int DW     = SUM_W + $clog2(MAX_HALF + 1) + 1;
    localparam int CMP_W  = ((DW > TW_W) ? DW : TW_W) + 2;
    localparam int TWA_W  = THR_W + LANE_W;
    localparam int FC_W   = $clog2(FIFO_DEPTH + 1);
    localparam int NEED_W = $clog2(FIFO_DEPTH + 8) + 1;
    localparam int HOLD_W = $clog2(CFG_SETTLE + 1);

    // configuration registers
    logic [THR_W-1:0]  r_thr;
    logic [LEN_W-1:0]  r_hl;
    logic [LANE_W-1:0] r_lanes;
    logic [DEP_W-1:0]  r_depth;
    logic              r_pick;
    logic              r_pol;
    logic              r_multi;
    logic [HOLD_W-1:0] r_cfg_hold;

    logic [LEN_W-1:0]  len_eff;
    logic [LANE_W-1:0] w_eff;
    logic [TWA_W-1:0]  r_tw_a;
    logic [TW_W-1:0]   r_tw;

    logic              accept;
    logic [PIX_W-1:0]  pix [IN_LANES];
    logic [SUM_W-1:0]  lane_sum;

    logic [SUM_W-1:0]       cell_sum  [WIN];
    logic signed [SUM_W:0]  cell_term [WIN];
    logic [COORD_W-1:0]     r_coord   [DLY];
    logic [COORD_W-1:0]     here;

    logic              r_acc;
    logic              r_acc_eos;
    logic [PW-1:0]     r_count;
    logic [PW-1:0]     n_count;
    logic              border;

    t_cand                   cand;
    logic signed [CMP_W-1:0] cand_c;
    logic [COORD_W-1:0]      cand_here;
    t_pipe_stat              pipe_stat;

    t_result           res0;
    t_result           res1;
    logic [1:0]        push_n;
    t_result           out_res;
    logic [FC_W-1:0]   fifo_cnt;
    logic [2:0]        inflight;
    logic [NEED_W-1:0] need;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_EDGE_THRESHOLD;
            r_hl    <= RST_HALF_LENGTH;
            r_lanes <= RST_LANES_USED;
            r_depth <= RST_DEPTH_LIMIT;
            r_pick  <= RST_PICK_FIRST;
            r_pol   <= RST_POLARITY;
            r_multi <= RST_MULTI_POINT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_EDGE_THRESHOLD: r_thr   <= i_cfg_data;
                REG_HALF_LENGTH:    r_hl    <= i_cfg_data[LEN_W-1:0];
                REG_LANES_USED:     r_lanes <= i_cfg_data[LANE_W-1:0];
                REG_DEPTH_LIMIT:    r_depth <= i_cfg_data;
                REG_PICK_FIRST:     r_pick  <= i_cfg_data[0];
                REG_POLARITY:       r_pol   <= i_cfg_data[0];
                REG_MULTI_POINT:    r_multi <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= '0;
        end else if (i_cfg_valid) begin
            r_cfg_hold <= HOLD_W'(CFG_SETTLE);
        end else if (r_cfg_hold != '0) begin
            r_cfg_hold <= r_cfg_hold - HOLD_W'(1);
        end
    end

    // out-of-range register values folded to the nearest legal setting
    always_comb begin
        len_eff = (r_hl == '0) ? LEN_W'(1) : r_hl;
        if (32'(len_eff) > MAX_HALF) begin
            len_eff = LEN_W'(MAX_HALF);
        end
    end

    always_comb begin
        w_eff = (r_lanes == '0) ? LANE_W'(1) : r_lanes;
        if (32'(w_eff) > LIM) begin
            w_eff = LANE_W'(LIM);
        end
        if (!w_eff[0]) begin
            w_eff = w_eff - LANE_W'(1);
        end
    end

    // threshold * lanes * half length, one multiply per register
    always_ff @(posedge i_clk) begin
        r_tw_a <= TWA_W'(r_thr) * TWA_W'(w_eff);
        r_tw   <= TW_W'(r_tw_a) * TW_W'(len_eff);
    end

    // input side
    assign inflight = 3'(r_acc) + 3'(pipe_stat.s1_valid) + 3'(pipe_stat.s2_valid);
    assign need     = NEED_W'(fifo_cnt) + NEED_W'({inflight, 1'b0}) + NEED_W'(2);
    assign o_stall  = (r_cfg_hold != '0) || i_cfg_valid || (need > NEED_W'(FIFO_DEPTH));
    assign accept   = i_valid && !o_stall;

    assign pix[0] = i_pix_a;
    assign pix[1] = i_pix_b;
    assign pix[2] = i_pix_c;
    assign pix[3] = i_pix_d;
    assign pix[4] = i_pix_e;

    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < IN_LANES; i++) begin
            if (LANE_W'(i) < w_eff) begin
                lane_sum = lane_sum + SUM_W'(pix[i]);
            end
        end
    end

    // window of lane sums, newest in cell 0
    for (genvar k = 0; k < WIN; k++) begin : g_cell
        if (k == 0) begin : g_head
            sepd_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (accept),
                .i_sum   (lane_sum),
                .i_len   (len_eff),
                .o_sum   (cell_sum[k]),
                .o_term  (cell_term[k])
            );
        end else begin : g_body
            sepd_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (accept),
                .i_sum   (cell_sum[k-1]),
                .i_len   (len_eff),
                .o_sum   (cell_sum[k]),
                .o_term  (cell_term[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coord[0] <= {i_pos_y, i_pos_x};
            for (int k = 1; k < DLY; k++) begin
                r_coord[k] <= r_coord[k-1];
            end
        end
    end

    assign here   = r_coord[CI_W'(len_eff)];
    assign border = 32'(r_count) >= ((32'(len_eff) << 1) + 32'd1);

    // position count restarts once the end-of-scan position has been read out
    always_comb begin
        n_count = (r_acc && r_acc_eos) ? '0 : r_count;
        if (accept && 32'(n_count) < MAX_SCAN) begin
            n_count = n_count + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 1'b0;
            r_acc_eos <= 1'b0;
            r_count   <= '0;
        end else begin
            r_acc     <= accept;
            r_acc_eos <= accept && i_end_of_scan;
            r_count   <= n_count;
        end
    end

    sepd_sum_tree #(
        .MAX_HALF (MAX_HALF),
        .CMP_W    (CMP_W)
    ) u_sum_tree (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_term     (cell_term),
        .i_valid    (r_acc),
        .i_eos      (r_acc_eos),
        .i_border   (border),
        .i_here     (here),
        .i_polarity (r_pol),
        .i_tw       (r_tw),
        .o_cand     (cand),
        .o_c        (cand_c),
        .o_here     (cand_here),
        .o_stat     (pipe_stat)
    );

    sepd_decide #(
        .CMP_W    (CMP_W),
        .MAX_SCAN (MAX_SCAN)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand       (cand),
        .i_c          (cand_c),
        .i_here       (cand_here),
        .i_pick_first (r_pick),
        .i_multi      (r_multi),
        .i_depth      (r_depth),
        .o_res0       (res0),
        .o_res1       (res1),
        .o_push_n     (push_n)
    );

    sepd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_stall  (i_stall),
        .o_res    (out_res),
        .o_valid  (o_valid),
        .o_count  (fifo_cnt)
    );

    assign o_kind         = out_res.kind;
    assign o_found        = out_res.found;
    assign o_edge_x       = out_res.edge_x;
    assign o_edge_y       = out_res.edge_y;
    assign o_points_found = out_res.points_found;
    assign o_last         = out_res.last;

endmodule

### rtl/sepd_checker.sv
// port-level checks for the scan-line edge point detector, bound to the top level
module sepd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_kind,
    input logic                              o_found,
    input logic [sepd_pkg::POS_W-1:0]        o_edge_x,
    input logic [sepd_pkg::POS_W-1:0]        o_edge_y,
    input logic [sepd_pkg::PTS_W-1:0]        o_points_found,
    input logic                              o_last,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);
    import sepd_pkg::*;

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a register write holds off input transfers on the following cycle
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_stall)
        else $error("input taken while configuration settles");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_found)
            && $stable(o_edge_x) && $stable(o_edge_y) && $stable(o_points_found)
            && $stable(o_last))
        else $error("stalled result changed");

    // points are always found and never close a scan, summaries always do
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == KIND_POINT) && o_found && !o_last)
            || ((o_kind == KIND_SUMMARY) && o_last))
        else $error("result kind does not match found or last");

endmodule

bind scanline_edge_point_detector_top sepd_checker u_sepd_checker (.*);
